@@ rtl/phdb_pkg.sv @@
// ----------------------------------------------------------------------------
// phdb_pkg
// Shared types and constants for the peak-hold decay bar meter.
// ----------------------------------------------------------------------------
package phdb_pkg;

  localparam int MAX_BANDS  = 16;
  localparam int BANDS      = 16;
  localparam int LEVEL_W    = 8;
  localparam int HALF_W     = MAX_BANDS / 2;
  localparam int WORD_W     = HALF_W * LEVEL_W;
  localparam int MS_W       = 16;
  localparam int HOLD_W     = 8;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [MS_W-1:0]   MS_RESET        = {MS_W{1'b1}};
  localparam logic [MS_W-1:0]   HALF_PERIOD_RST = MS_W'(16);
  localparam logic [HOLD_W-1:0] HOLD_FRAMES_RST = HOLD_W'(4);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_FRAME = 2'd1,
    OP_BLANK = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_PERIOD = 1'b0,
    REG_HOLD_FRAMES = 1'b1
  } reg_idx_t;

  // per-band update command, shared by all lanes
  typedef struct packed {
    logic              en;
    logic              has_data;
    logic              allowed;
    logic [HOLD_W-1:0] hold_frames;
  } lane_ctl_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } q_status_t;

endpackage

@@ rtl/phdb_if.sv @@
// ----------------------------------------------------------------------------
// phdb_in_if / phdb_out_if
// Valid/ready channels for frame items and bar results.
// ----------------------------------------------------------------------------
interface phdb_in_if;
  logic                          valid;
  logic                          ready;
  logic [phdb_pkg::OP_W-1:0]     operation;
  logic [phdb_pkg::WORD_W-1:0]   levels_low;
  logic [phdb_pkg::WORD_W-1:0]   levels_high;

  modport source (output valid, operation, levels_low, levels_high, input ready);
  modport sink   (input valid, operation, levels_low, levels_high, output ready);
endinterface

interface phdb_out_if;
  logic                          valid;
  logic                          ready;
  logic [phdb_pkg::WORD_W-1:0]   bars_low;
  logic [phdb_pkg::WORD_W-1:0]   bars_high;
  logic                          decay_done;

  modport source (output valid, bars_low, bars_high, decay_done, input ready);
  modport sink   (input valid, bars_low, bars_high, decay_done, output ready);
endinterface

@@ rtl/peak_hold_decay_bars_core.sv @@
// ----------------------------------------------------------------------------
// peak_hold_decay_bars_core
// Peak-hold bar meter: one lane per band, shared decay timer, output queue.
// ----------------------------------------------------------------------------
// Each frame item's result is registered in the output queue (main or skid).
// One item per cycle while not stalled; all band lanes update in that same cycle.
// Input stalls only when both output entries are full (main and skid).
// Reset (rst, synchronous): bars and holds clear, the decay counter loads
// all ones, registers take their defaults, the output queue empties.
// ----------------------------------------------------------------------------
module peak_hold_decay_bars_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [phdb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [phdb_pkg::CFG_DATA_W-1:0]   cfg_data,
  phdb_in_if.sink                           items,
  phdb_out_if.source                        results
);

  logic [phdb_pkg::MS_W-1:0]   half_period_ms;
  logic [phdb_pkg::HOLD_W-1:0] hold_frames;
  logic                        accept;
  logic                        tick;
  logic                        frame;
  logic                        allowed;
  phdb_pkg::lane_ctl_t         ctl;
  phdb_pkg::q_status_t         q_status;
  logic [2*phdb_pkg::WORD_W-1:0]                       levels;
  logic [phdb_pkg::MAX_BANDS*phdb_pkg::LEVEL_W-1:0]    bars;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ms <= phdb_pkg::HALF_PERIOD_RST;
      hold_frames    <= phdb_pkg::HOLD_FRAMES_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        phdb_pkg::REG_HALF_PERIOD: half_period_ms <= cfg_data[phdb_pkg::MS_W-1:0];
        phdb_pkg::REG_HOLD_FRAMES: hold_frames    <= cfg_data[phdb_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign items.ready = !q_status.skid_valid;
  assign accept      = items.valid && items.ready;
  assign tick        = accept && items.operation == phdb_pkg::OP_TICK;
  assign frame       = accept && (items.operation == phdb_pkg::OP_FRAME ||
                                  items.operation == phdb_pkg::OP_BLANK);
  assign levels      = {items.levels_high, items.levels_low};

  assign ctl.en          = frame;
  assign ctl.has_data    = items.operation == phdb_pkg::OP_FRAME;
  assign ctl.allowed     = allowed;
  assign ctl.hold_frames = hold_frames;

  phdb_timer u_timer (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .frame          (frame),
    .half_period_ms (half_period_ms),
    .allowed        (allowed)
  );

  for (genvar b = 0; b < phdb_pkg::MAX_BANDS; b++) begin : g_band
    if (b < phdb_pkg::BANDS) begin : g_lane
      phdb_lane u_lane (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .level    (levels[b*phdb_pkg::LEVEL_W +: phdb_pkg::LEVEL_W]),
        .bar_next (bars[b*phdb_pkg::LEVEL_W +: phdb_pkg::LEVEL_W])
      );
    end else begin : g_unused
      // band above the configured count reads zero
      assign bars[b*phdb_pkg::LEVEL_W +: phdb_pkg::LEVEL_W] = '0;
    end
  end

  phdb_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .push       (frame),
    .bars       (bars),
    .decay_done (allowed),
    .status     (q_status),
    .results    (results)
  );

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    q_status.skid_valid |-> q_status.main_valid)
    else $error("skid entry held without a main entry");

  a_frame_gives_result: assert property (@(posedge clk) disable iff (rst)
    frame |=> results.valid)
    else $error("frame item left no result");

  a_tick_keeps_result: assert property (@(posedge clk) disable iff (rst)
    (tick && results.valid && !results.ready) |=> results.valid)
    else $error("pending result lost on a tick");

  a_decay_restarts: assert property (@(posedge clk) disable iff (rst)
    (frame && allowed) |=> !allowed)
    else $error("decay allowed twice without a tick between");

endmodule

@@ rtl/phdb_timer.sv @@
// ----------------------------------------------------------------------------
// phdb_timer
// Millisecond counter since the last decay step and the decay allowance.
// ----------------------------------------------------------------------------
module phdb_timer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick,
  input  logic                          frame,
  input  logic [phdb_pkg::MS_W-1:0]     half_period_ms,
  output logic                          allowed
);

  logic [phdb_pkg::MS_W-1:0] ms_since_decay;
  logic [phdb_pkg::MS_W-1:0] ms_since_decay_next;

  assign allowed = ms_since_decay > half_period_ms;

  always_comb begin
    ms_since_decay_next = ms_since_decay;
    if (tick && ms_since_decay != phdb_pkg::MS_RESET) begin
      ms_since_decay_next = ms_since_decay + phdb_pkg::MS_W'(1);
    end else if (frame && allowed) begin
      ms_since_decay_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_since_decay <= phdb_pkg::MS_RESET;
    end else begin
      ms_since_decay <= ms_since_decay_next;
    end
  end

endmodule

@@ rtl/phdb_lane.sv @@
// ----------------------------------------------------------------------------
// phdb_lane
// One band: bar level and hold counter with jump-up and hold-then-fall.
// ----------------------------------------------------------------------------
module phdb_lane (
  input  logic                            clk,
  input  logic                            rst,
  input  phdb_pkg::lane_ctl_t             ctl,
  input  logic [phdb_pkg::LEVEL_W-1:0]    level,
  output logic [phdb_pkg::LEVEL_W-1:0]    bar_next
);

  logic [phdb_pkg::LEVEL_W-1:0] bar_level;
  logic [phdb_pkg::HOLD_W-1:0]  hold_count;
  logic [phdb_pkg::HOLD_W-1:0]  hold_count_next;
  logic                         decay;

  assign decay = ctl.allowed && (!ctl.has_data || level < bar_level);

  always_comb begin
    bar_next        = bar_level;
    hold_count_next = hold_count;
    if (ctl.en) begin
      if (ctl.has_data && level > bar_level) begin
        bar_next        = level;
        hold_count_next = ctl.hold_frames;
      end else if (decay) begin
        // spend the hold first, then fall by one
        if (hold_count != '0) begin
          hold_count_next = hold_count - phdb_pkg::HOLD_W'(1);
        end else if (bar_level != '0) begin
          bar_next = bar_level - phdb_pkg::LEVEL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_level  <= '0;
      hold_count <= '0;
    end else begin
      bar_level  <= bar_next;
      hold_count <= hold_count_next;
    end
  end

endmodule

@@ rtl/phdb_merge.sv @@
// ----------------------------------------------------------------------------
// phdb_merge
// Packs the lane bars into result words and holds them in a two-deep
// output register with skid entry.
// ----------------------------------------------------------------------------
module phdb_merge (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         push,
  input  logic [phdb_pkg::MAX_BANDS*phdb_pkg::LEVEL_W-1:0] bars,
  input  logic                                         decay_done,
  output phdb_pkg::q_status_t                          status,
  phdb_out_if.source                                   results
);

  logic                          main_valid;
  logic [phdb_pkg::WORD_W-1:0]   main_low;
  logic [phdb_pkg::WORD_W-1:0]   main_high;
  logic                          main_done;
  logic                          skid_valid;
  logic [phdb_pkg::WORD_W-1:0]   skid_low;
  logic [phdb_pkg::WORD_W-1:0]   skid_high;
  logic                          skid_done;
  logic                          pop;

  assign pop                = main_valid && results.ready;
  assign results.valid      = main_valid;
  assign results.bars_low   = main_low;
  assign results.bars_high  = main_high;
  assign results.decay_done = main_done;
  assign status.main_valid  = main_valid;
  assign status.skid_valid  = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // no push while the skid entry is full
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end
      main_valid <= 1'b1;
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_low  <= skid_low;
        main_high <= skid_high;
        main_done <= skid_done;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_low  <= bars[phdb_pkg::WORD_W-1:0];
        skid_high <= bars[2*phdb_pkg::WORD_W-1:phdb_pkg::WORD_W];
        skid_done <= decay_done;
      end else begin
        main_low  <= bars[phdb_pkg::WORD_W-1:0];
        main_high <= bars[2*phdb_pkg::WORD_W-1:phdb_pkg::WORD_W];
        main_done <= decay_done;
      end
    end
  end

endmodule
